### hdl/etts_pkg.sv
// shared types, constants and sine table builder for the three-tone synth
`default_nettype none

package etts_pkg;

   // sine table and phase accumulator geometry
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int SINE_ADDR_WIDTH  = $clog2(SINE_TABLE_DEPTH);
   localparam int PHASE_WIDTH      = 32;

   // field widths
   localparam int INDEX_WIDTH  = 24;
   localparam int INC_WIDTH    = 32;
   localparam int LEN_WIDTH    = 24;
   localparam int SLOPE_WIDTH  = 25;
   localparam int SAMPLE_WIDTH = 16;
   localparam int PHASE_PROD_WIDTH = INDEX_WIDTH + INC_WIDTH;

   // envelope gains are Q24 with unity representable
   localparam int GAIN_FRAC  = 24;
   localparam int GAIN_WIDTH = GAIN_FRAC + 1;
   localparam int RAMP_PROD_WIDTH = LEN_WIDTH + SLOPE_WIDTH;
   localparam int GAIN_PROD_WIDTH = 2 * GAIN_WIDTH;
   localparam logic [GAIN_WIDTH-1:0] UNITY_GAIN = GAIN_WIDTH'(1) << GAIN_FRAC;

   // volume 0.3 as Q16
   localparam int VOLUME_FRAC  = 16;
   localparam int VOLUME_WIDTH = 15;
   localparam logic [VOLUME_WIDTH-1:0] VOLUME_Q16 = VOLUME_WIDTH'(19661);

   // datapath widths after each multiply
   localparam int SUM_WIDTH         = SAMPLE_WIDTH + 2;
   localparam int SCALED_FULL_WIDTH = SUM_WIDTH + VOLUME_WIDTH + 1;
   localparam int SCALED_WIDTH      = 32;
   localparam int PRODUCT_WIDTH     = SCALED_WIDTH + GAIN_WIDTH + 1;
   localparam int OUT_SHIFT         = VOLUME_FRAC + GAIN_FRAC;
   localparam int MAG_WIDTH         = PRODUCT_WIDTH - OUT_SHIFT;

   // configuration port
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 5;

   typedef enum logic [2:0] {
      REG_PHASE_INC_A     = 3'd0,
      REG_PHASE_INC_B     = 3'd1,
      REG_PHASE_INC_C     = 3'd2,
      REG_ATTACK_SAMPLES  = 3'd3,
      REG_RELEASE_SAMPLES = 3'd4,
      REG_TOTAL_SAMPLES   = 3'd5,
      REG_ATTACK_SLOPE    = 3'd6,
      REG_RELEASE_SLOPE   = 3'd7
   } csr_reg_type;

   localparam logic [INC_WIDTH-1:0]   PHASE_INC_A_RESET     = INC_WIDTH'(25481000);
   localparam logic [INC_WIDTH-1:0]   PHASE_INC_B_RESET     = INC_WIDTH'(32103000);
   localparam logic [INC_WIDTH-1:0]   PHASE_INC_C_RESET     = INC_WIDTH'(38178000);
   localparam logic [LEN_WIDTH-1:0]   ATTACK_SAMPLES_RESET  = LEN_WIDTH'(22050);
   localparam logic [LEN_WIDTH-1:0]   RELEASE_SAMPLES_RESET = LEN_WIDTH'(22050);
   localparam logic [LEN_WIDTH-1:0]   TOTAL_SAMPLES_RESET   = LEN_WIDTH'(88200);
   localparam logic [SLOPE_WIDTH-1:0] ATTACK_SLOPE_RESET    = SLOPE_WIDTH'(760);
   localparam logic [SLOPE_WIDTH-1:0] RELEASE_SLOPE_RESET   = SLOPE_WIDTH'(760);

   typedef struct packed {
      logic [INC_WIDTH-1:0]   phase_inc_a;
      logic [INC_WIDTH-1:0]   phase_inc_b;
      logic [INC_WIDTH-1:0]   phase_inc_c;
      logic [LEN_WIDTH-1:0]   attack_samples;
      logic [LEN_WIDTH-1:0]   release_samples;
      logic [LEN_WIDTH-1:0]   total_samples;
      logic [SLOPE_WIDTH-1:0] attack_slope;
      logic [SLOPE_WIDTH-1:0] release_slope;
   } cfg_type;

   typedef struct packed {
      logic [GAIN_WIDTH-1:0] attack_gain;
      logic [GAIN_WIDTH-1:0] release_gain;
      logic                  in_range;
      logic                  last;
   } env_type;

   typedef logic signed [SAMPLE_WIDTH-1:0] sine_table_type [SINE_TABLE_DEPTH];

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint          ONE_Q30     = 64'sd1 << 30;

   // sine of a quarter-turn fraction, both Q30, odd series up to x^13
   function automatic longint quarter_sine(input longint unsigned f);
      longint x;
      longint x2;
      longint term;
      longint sum;
      x    = longint'((f * HALF_PI_Q30) >> 30);
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >>> 30) / 6;
      sum  = sum - term;
      term = ((term * x2) >>> 30) / 20;
      sum  = sum + term;
      term = ((term * x2) >>> 30) / 42;
      sum  = sum - term;
      term = ((term * x2) >>> 30) / 72;
      sum  = sum + term;
      term = ((term * x2) >>> 30) / 110;
      sum  = sum - term;
      term = ((term * x2) >>> 30) / 156;
      sum  = sum + term;
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > ONE_Q30) begin
         sum = ONE_Q30;
      end
      return sum;
   endfunction

   // full-wave table, first quadrant from the series, the rest by symmetry
   function automatic sine_table_type build_sine_table();
      sine_table_type  tbl;
      longint unsigned ph;
      longint unsigned quad;
      longint unsigned frac;
      longint          s;
      longint          v;
      for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
         ph   = (longint'(i) << 32) / SINE_TABLE_DEPTH;
         quad = (ph >> 30) & 64'd3;
         frac = ph & ((64'd1 << 30) - 64'd1);
         if (quad[0]) begin
            frac = (64'd1 << 30) - frac;
         end
         s = quarter_sine(frac);
         v = (s * 32767 + (64'sd1 <<< 29)) >>> 30;
         if (quad >= 64'd2) begin
            v = -v;
         end
         tbl[i] = v[SAMPLE_WIDTH-1:0];
      end
      return tbl;
   endfunction

endpackage

`default_nettype wire

### hdl/etts_ifs.sv
// handshake channel interfaces for sample requests and pcm results
`default_nettype none

interface etts_req_if import etts_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [INDEX_WIDTH-1:0] sample_index;

   modport source (output valid, output sample_index, input ready);
   modport sink (input valid, input sample_index, output ready);
endinterface

interface etts_rsp_if import etts_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] pcm_sample;
   logic                           last_sample;

   modport source (output valid, output pcm_sample, output last_sample, input ready);
   modport sink (input valid, input pcm_sample, input last_sample, output ready);
endinterface

`default_nettype wire

### hdl/etts_csr.sv
// apb register file holding the tone, ramp and note length settings
`default_nettype none

module etts_csr import etts_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output cfg_type                   cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   csr_reg_type reg_sel;
   logic        wr_en;

   assign pready  = 1'b1;
   assign reg_sel = csr_reg_type'(paddr[CSR_ADDR_WIDTH-1:2]);
   assign wr_en   = psel && penable && pwrite;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_PHASE_INC_A:     cfg_in.phase_inc_a     = pwdata[INC_WIDTH-1:0];
            REG_PHASE_INC_B:     cfg_in.phase_inc_b     = pwdata[INC_WIDTH-1:0];
            REG_PHASE_INC_C:     cfg_in.phase_inc_c     = pwdata[INC_WIDTH-1:0];
            REG_ATTACK_SAMPLES:  cfg_in.attack_samples  = pwdata[LEN_WIDTH-1:0];
            REG_RELEASE_SAMPLES: cfg_in.release_samples = pwdata[LEN_WIDTH-1:0];
            REG_TOTAL_SAMPLES:   cfg_in.total_samples   = pwdata[LEN_WIDTH-1:0];
            REG_ATTACK_SLOPE:    cfg_in.attack_slope    = pwdata[SLOPE_WIDTH-1:0];
            REG_RELEASE_SLOPE:   cfg_in.release_slope   = pwdata[SLOPE_WIDTH-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_PHASE_INC_A:     prdata = CSR_DATA_WIDTH'(cfg_ff.phase_inc_a);
         REG_PHASE_INC_B:     prdata = CSR_DATA_WIDTH'(cfg_ff.phase_inc_b);
         REG_PHASE_INC_C:     prdata = CSR_DATA_WIDTH'(cfg_ff.phase_inc_c);
         REG_ATTACK_SAMPLES:  prdata = CSR_DATA_WIDTH'(cfg_ff.attack_samples);
         REG_RELEASE_SAMPLES: prdata = CSR_DATA_WIDTH'(cfg_ff.release_samples);
         REG_TOTAL_SAMPLES:   prdata = CSR_DATA_WIDTH'(cfg_ff.total_samples);
         REG_ATTACK_SLOPE:    prdata = CSR_DATA_WIDTH'(cfg_ff.attack_slope);
         REG_RELEASE_SLOPE:   prdata = CSR_DATA_WIDTH'(cfg_ff.release_slope);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_inc_a     <= PHASE_INC_A_RESET;
         cfg_ff.phase_inc_b     <= PHASE_INC_B_RESET;
         cfg_ff.phase_inc_c     <= PHASE_INC_C_RESET;
         cfg_ff.attack_samples  <= ATTACK_SAMPLES_RESET;
         cfg_ff.release_samples <= RELEASE_SAMPLES_RESET;
         cfg_ff.total_samples   <= TOTAL_SAMPLES_RESET;
         cfg_ff.attack_slope    <= ATTACK_SLOPE_RESET;
         cfg_ff.release_slope   <= RELEASE_SLOPE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

### hdl/etts_sine_rom.sv
// full-wave sine rom with registered read
`default_nettype none

module etts_sine_rom import etts_pkg::*; (
   input  logic                           clock,
   input  logic                           en,
   input  logic [SINE_ADDR_WIDTH-1:0]     addr,
   output logic signed [SAMPLE_WIDTH-1:0] data
);

   localparam sine_table_type SineTable = build_sine_table();

   logic signed [SAMPLE_WIDTH-1:0] data_ff;

   assign data = data_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= SineTable[addr];
      end
   end

endmodule

`default_nettype wire

### hdl/etts_envelope.sv
// attack and release ramp gains plus note range flags for one sample index
`default_nettype none

module etts_envelope import etts_pkg::*; (
   input  logic [INDEX_WIDTH-1:0] sample_index,
   input  cfg_type                cfg,
   output env_type                env
);

   logic [RAMP_PROD_WIDTH-1:0] attack_prod;
   logic [RAMP_PROD_WIDTH-1:0] release_prod;
   logic [LEN_WIDTH-1:0]       release_count;
   logic [LEN_WIDTH:0]         release_edge;
   logic                       in_attack;
   logic                       in_release;

   assign attack_prod   = RAMP_PROD_WIDTH'(sample_index) * RAMP_PROD_WIDTH'(cfg.attack_slope);
   assign release_count = cfg.total_samples - sample_index;
   assign release_prod  = RAMP_PROD_WIDTH'(release_count) *
                          RAMP_PROD_WIDTH'(cfg.release_slope);
   assign release_edge  = (LEN_WIDTH + 1)'(sample_index) +
                          (LEN_WIDTH + 1)'(cfg.release_samples);
   assign in_attack     = sample_index < cfg.attack_samples;
   assign in_release    = release_edge > (LEN_WIDTH + 1)'(cfg.total_samples);

   always_comb begin
      env.attack_gain  = UNITY_GAIN;
      env.release_gain = UNITY_GAIN;
      // each ramp saturates at unity
      if (in_attack && (attack_prod < RAMP_PROD_WIDTH'(UNITY_GAIN))) begin
         env.attack_gain = attack_prod[GAIN_WIDTH-1:0];
      end
      if (in_release && (release_prod < RAMP_PROD_WIDTH'(UNITY_GAIN))) begin
         env.release_gain = release_prod[GAIN_WIDTH-1:0];
      end
      env.in_range = sample_index < cfg.total_samples;
      env.last     = ((LEN_WIDTH + 1)'(sample_index) + (LEN_WIDTH + 1)'(1)) ==
                     (LEN_WIDTH + 1)'(cfg.total_samples);
   end

endmodule

`default_nettype wire

### hdl/enveloped_three_tone_synth_core.sv
// top level: six-stage pipeline from sample index to enveloped pcm sample
// each accepted item moves through the stage registers in order; its result is valid once it reaches the last stage
// throughput: one item per cycle while the receiver keeps ready high; each stage holds at most one multiplier per path
// and the three sine roms are read through a registered port
// stalls propagate stage by stage, so bubbles are squeezed out behind a held result
// reset: synchronous, clears every stage valid and loads the register defaults
`default_nettype none

module enveloped_three_tone_synth_core import etts_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   etts_req_if.sink                  req_bus,
   etts_rsp_if.source                rsp_bus,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   cfg_type cfg;

   etts_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // stage valids and per-stage advance
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic en1, en2, en3, en4, en5, en6;

   assign en6 = !v6_ff || rsp_bus.ready;
   assign en5 = !v5_ff || en6;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_bus.ready = en1;
   assign rsp_bus.valid = v6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_bus.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
      end
   end

   // stage 1: index register
   logic [INDEX_WIDTH-1:0] n1_ff;

   // stage 2: phases and ramp gains
   logic [PHASE_PROD_WIDTH-1:0] phase_prod_a, phase_prod_b, phase_prod_c;
   logic [SINE_ADDR_WIDTH-1:0]  addr_a_in, addr_b_in, addr_c_in;
   logic [SINE_ADDR_WIDTH-1:0]  addr_a2_ff, addr_b2_ff, addr_c2_ff;
   env_type                     env_in;
   env_type                     env2_ff;

   assign phase_prod_a = PHASE_PROD_WIDTH'(n1_ff) * PHASE_PROD_WIDTH'(cfg.phase_inc_a);
   assign phase_prod_b = PHASE_PROD_WIDTH'(n1_ff) * PHASE_PROD_WIDTH'(cfg.phase_inc_b);
   assign phase_prod_c = PHASE_PROD_WIDTH'(n1_ff) * PHASE_PROD_WIDTH'(cfg.phase_inc_c);

   // table address is the top of the wrapped phase
   assign addr_a_in = phase_prod_a[PHASE_WIDTH-1 -: SINE_ADDR_WIDTH];
   assign addr_b_in = phase_prod_b[PHASE_WIDTH-1 -: SINE_ADDR_WIDTH];
   assign addr_c_in = phase_prod_c[PHASE_WIDTH-1 -: SINE_ADDR_WIDTH];

   etts_envelope u_envelope (
      .sample_index (n1_ff),
      .cfg          (cfg),
      .env          (env_in)
   );

   // stage 3: rom reads and combined gain
   logic signed [SAMPLE_WIDTH-1:0] rom_a3, rom_b3, rom_c3;
   logic [GAIN_PROD_WIDTH-1:0]     gain_prod;
   logic [GAIN_WIDTH-1:0]          gain_in;
   logic [GAIN_WIDTH-1:0]          gain3_ff;
   logic                           in_range3_ff, last3_ff;

   etts_sine_rom u_rom_a (.clock(clock), .en(en3), .addr(addr_a2_ff), .data(rom_a3));
   etts_sine_rom u_rom_b (.clock(clock), .en(en3), .addr(addr_b2_ff), .data(rom_b3));
   etts_sine_rom u_rom_c (.clock(clock), .en(en3), .addr(addr_c2_ff), .data(rom_c3));

   assign gain_prod = GAIN_PROD_WIDTH'(env2_ff.attack_gain) *
                      GAIN_PROD_WIDTH'(env2_ff.release_gain);
   assign gain_in   = gain_prod[GAIN_FRAC +: GAIN_WIDTH];

   // stage 4: tone sum times volume
   logic signed [SUM_WIDTH-1:0]         tone_sum;
   logic signed [SCALED_FULL_WIDTH-1:0] scaled_full;
   logic signed [SCALED_WIDTH-1:0]      scaled4_ff;
   logic [GAIN_WIDTH-1:0]               gain4_ff;
   logic                                in_range4_ff, last4_ff;

   assign tone_sum    = SUM_WIDTH'(rom_a3) + SUM_WIDTH'(rom_b3) + SUM_WIDTH'(rom_c3);
   assign scaled_full = tone_sum * $signed({1'b0, VOLUME_Q16});

   // stage 5: times envelope gain
   logic signed [PRODUCT_WIDTH-1:0] product_in;
   logic signed [PRODUCT_WIDTH-1:0] product5_ff;
   logic                            in_range5_ff, last5_ff;

   assign product_in = scaled4_ff * $signed({1'b0, gain4_ff});

   // stage 6: truncate toward zero and saturate
   logic [PRODUCT_WIDTH-1:0]       product_mag;
   logic [MAG_WIDTH-1:0]           mag_hi;
   logic [SAMPLE_WIDTH:0]          mag_sat;
   logic signed [SAMPLE_WIDTH:0]   pcm_wide;
   logic signed [SAMPLE_WIDTH-1:0] pcm_in;
   logic signed [SAMPLE_WIDTH-1:0] pcm6_ff;
   logic                           last6_ff;

   localparam logic [SAMPLE_WIDTH:0] MagLimit = (SAMPLE_WIDTH + 1)'(1) << (SAMPLE_WIDTH - 1);
   localparam logic signed [SAMPLE_WIDTH:0] PcmMax = $signed(MagLimit - 1'b1);

   always_comb begin
      product_mag = product5_ff[PRODUCT_WIDTH-1] ? PRODUCT_WIDTH'(-product5_ff)
                                                 : PRODUCT_WIDTH'(product5_ff);
      mag_hi      = product_mag[OUT_SHIFT +: MAG_WIDTH];
      if (mag_hi > MAG_WIDTH'(MagLimit)) begin
         mag_sat = MagLimit;
      end else begin
         mag_sat = mag_hi[SAMPLE_WIDTH:0];
      end
      pcm_wide = product5_ff[PRODUCT_WIDTH-1] ? -$signed(mag_sat) : $signed(mag_sat);
      if (pcm_wide > PcmMax) begin
         pcm_wide = PcmMax;
      end
      // past the note end the output is forced to zero
      if (!in_range5_ff) begin
         pcm_in = '0;
      end else begin
         pcm_in = pcm_wide[SAMPLE_WIDTH-1:0];
      end
   end

   assign rsp_bus.pcm_sample  = pcm6_ff;
   assign rsp_bus.last_sample = last6_ff;

   always_ff @(posedge clock) begin
      if (en1) begin
         n1_ff <= req_bus.sample_index;
      end
      if (en2) begin
         addr_a2_ff <= addr_a_in;
         addr_b2_ff <= addr_b_in;
         addr_c2_ff <= addr_c_in;
         env2_ff    <= env_in;
      end
      if (en3) begin
         gain3_ff     <= gain_in;
         in_range3_ff <= env2_ff.in_range;
         last3_ff     <= env2_ff.last;
      end
      if (en4) begin
         scaled4_ff   <= scaled_full[SCALED_WIDTH-1:0];
         gain4_ff     <= gain3_ff;
         in_range4_ff <= in_range3_ff;
         last4_ff     <= last3_ff;
      end
      if (en5) begin
         product5_ff  <= product_in;
         in_range5_ff <= in_range4_ff;
         last5_ff     <= last4_ff;
      end
      if (en6) begin
         pcm6_ff  <= pcm_in;
         last6_ff <= last5_ff;
      end
   end

`ifndef SYNTHESIS
   a_last_in_range: assert property (@(posedge clock) disable iff (reset)
      v2_ff && env2_ff.last |-> env2_ff.in_range)
      else $error("last sample flagged outside the note");

   a_gain_unity: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> gain3_ff <= UNITY_GAIN)
      else $error("combined gain above unity");

   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      v5_ff && en6 && !in_range5_ff |=> rsp_bus.pcm_sample == '0)
      else $error("nonzero sample past note end");

   a_stage1_hold: assert property (@(posedge clock) disable iff (reset)
      v1_ff && !en2 |=> v1_ff && $stable(n1_ff))
      else $error("stalled item lost in first stage");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !v6_ff && !v1_ff)
      else $error("valid survived reset");
`endif

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// testbench for the three-tone synth core: predicts every pcm sample and checks it
`timescale 1ns / 100ps

module testbench;
   import etts_pkg::*;

   localparam int     CYCLE_LIMIT      = 400000;
   localparam int     DRAIN_CYCLES     = 12;
   localparam int     HOLD_CYCLES      = 300;
   localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
   localparam longint UNITY_Q24        = 64'sd1 <<< GAIN_FRAC;
   localparam longint MAX_INDEX        = (64'sd1 <<< INDEX_WIDTH) - 1;

   typedef struct {
      logic signed [SAMPLE_WIDTH-1:0] pcm_sample;
      logic                           last_sample;
   } pcm_item_type;

   logic                      clock;
   logic                      reset;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   etts_req_if req_bus ();
   etts_rsp_if rsp_bus ();

   enveloped_three_tone_synth_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   logic signed [SAMPLE_WIDTH-1:0] sine_words [SINE_TABLE_DEPTH];
   cfg_type      note_cfg;
   pcm_item_type pcm_expect [$];
   int           mismatches     = 0;
   int           cycle_count    = 0;
   int           send_idle_pct  = 0;
   int           recv_stall_pct = 0;
   int           stall_hold     = 0;
   int           hold_requests  = 0;
   int           hold_served    = 0;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // full-wave sine table, first quadrant from the odd series, rest by symmetry
   function automatic void tabulate_sine();
      longint ph;
      longint quad;
      longint frac;
      longint x;
      longint x2;
      longint term;
      longint acc;
      longint v;
      for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
         ph   = (longint'(i) <<< 32) / SINE_TABLE_DEPTH;
         quad = (ph >>> 30) & 3;
         frac = ph & ((64'sd1 <<< 30) - 1);
         if (quad[0]) begin
            frac = (64'sd1 <<< 30) - frac;
         end
         x    = (frac * QUARTER_TURN_Q30) >>> 30;
         x2   = (x * x) >>> 30;
         term = x;
         acc  = x;
         for (int k = 1; k <= 6; k++) begin
            term = ((term * x2) >>> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
               acc = acc - term;
            end else begin
               acc = acc + term;
            end
         end
         if (acc < 0) begin
            acc = 0;
         end
         if (acc > (64'sd1 <<< 30)) begin
            acc = 64'sd1 <<< 30;
         end
         v = (acc * 32767 + (64'sd1 <<< 29)) >>> 30;
         if (quad >= 2) begin
            v = -v;
         end
         sine_words[i] = v[SAMPLE_WIDTH-1:0];
      end
   endfunction

   function automatic longint tone_word(input logic [INDEX_WIDTH-1:0] n,
                                        input logic [INC_WIDTH-1:0] inc);
      logic [PHASE_PROD_WIDTH-1:0] prod;
      logic [PHASE_WIDTH-1:0]      phase;
      prod  = PHASE_PROD_WIDTH'(n) * PHASE_PROD_WIDTH'(inc);
      phase = prod[PHASE_WIDTH-1:0];
      return longint'(sine_words[phase[PHASE_WIDTH-1 -: SINE_ADDR_WIDTH]]);
   endfunction

   function automatic longint ramp_gain(input longint count, input longint slope);
      longint g;
      g = count * slope;
      return (g > UNITY_Q24) ? UNITY_Q24 : g;
   endfunction

   // enveloped, scaled sum of the three tones for one sample index
   function automatic pcm_item_type synth_sample(input logic [INDEX_WIDTH-1:0] idx);
      pcm_item_type res;
      longint       n;
      longint       total;
      longint       ga;
      longint       gr;
      longint       gain;
      longint       tsum;
      longint       p;
      longint       mag;
      longint       pcm;
      n     = longint'(idx);
      total = longint'(note_cfg.total_samples);
      pcm   = 0;
      if (n < total) begin
         ga = UNITY_Q24;
         gr = UNITY_Q24;
         if (n < longint'(note_cfg.attack_samples)) begin
            ga = ramp_gain(n, longint'(note_cfg.attack_slope));
         end
         if (n + longint'(note_cfg.release_samples) > total) begin
            gr = ramp_gain(total - n, longint'(note_cfg.release_slope));
         end
         gain = (ga * gr) >>> GAIN_FRAC;
         tsum = tone_word(idx, note_cfg.phase_inc_a) + tone_word(idx, note_cfg.phase_inc_b)
              + tone_word(idx, note_cfg.phase_inc_c);
         p    = tsum * 19661 * gain;
         mag  = ((p < 0) ? -p : p) >>> OUT_SHIFT;
         if (mag > 32768) begin
            mag = 32768;
         end
         pcm = (p < 0) ? -mag : mag;
         if (pcm > 32767) begin
            pcm = 32767;
         end
      end
      res.pcm_sample  = pcm[SAMPLE_WIDTH-1:0];
      res.last_sample = (n + 1 == total);
      return res;
   endfunction

   function automatic logic [INDEX_WIDTH-1:0] clamp_index(input longint v);
      if (v < 0) begin
         return '0;
      end
      if (v > MAX_INDEX) begin
         return '1;
      end
      return v[INDEX_WIDTH-1:0];
   endfunction

   // mostly indices around the ramps and the note end, some anywhere
   function automatic logic [INDEX_WIDTH-1:0] random_index();
      longint total;
      longint att;
      longint rel;
      int     sel;
      total = longint'(note_cfg.total_samples);
      att   = longint'(note_cfg.attack_samples);
      rel   = longint'(note_cfg.release_samples);
      sel   = $urandom_range(99);
      if (sel < 35 && total > 0) begin
         return clamp_index(longint'($urandom_range(32'(total - 1), 0)));
      end else if (sel < 55) begin
         return clamp_index(longint'($urandom_range(32'((att > MAX_INDEX) ? MAX_INDEX
                                                         : att + 4), 0)));
      end else if (sel < 80) begin
         return clamp_index(total + 2
                            - longint'($urandom_range(32'((rel > MAX_INDEX) ? MAX_INDEX
                                                           : rel + 6), 0)));
      end else if (sel < 90) begin
         case ($urandom_range(6))
            0: return clamp_index(att - 1);
            1: return clamp_index(att);
            2: return clamp_index(total - rel);
            3: return clamp_index(total - rel - 1);
            4: return clamp_index(total - 1);
            5: return clamp_index(total);
            default: return clamp_index(total + 1);
         endcase
      end
      return INDEX_WIDTH'($urandom());
   endfunction

   task automatic csr_write(input csr_reg_type r, input logic [CSR_DATA_WIDTH-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_WIDTH'(int'(r) * 4);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (r)
         REG_PHASE_INC_A:     note_cfg.phase_inc_a     = value[INC_WIDTH-1:0];
         REG_PHASE_INC_B:     note_cfg.phase_inc_b     = value[INC_WIDTH-1:0];
         REG_PHASE_INC_C:     note_cfg.phase_inc_c     = value[INC_WIDTH-1:0];
         REG_ATTACK_SAMPLES:  note_cfg.attack_samples  = value[LEN_WIDTH-1:0];
         REG_RELEASE_SAMPLES: note_cfg.release_samples = value[LEN_WIDTH-1:0];
         REG_TOTAL_SAMPLES:   note_cfg.total_samples   = value[LEN_WIDTH-1:0];
         REG_ATTACK_SLOPE:    note_cfg.attack_slope    = value[SLOPE_WIDTH-1:0];
         REG_RELEASE_SLOPE:   note_cfg.release_slope   = value[SLOPE_WIDTH-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_note(input logic [31:0] inc_a, input logic [31:0] inc_b,
                             input logic [31:0] inc_c, input logic [31:0] att,
                             input logic [31:0] rel, input logic [31:0] total,
                             input logic [31:0] att_slope, input logic [31:0] rel_slope);
      csr_write(REG_PHASE_INC_A, inc_a);
      csr_write(REG_PHASE_INC_B, inc_b);
      csr_write(REG_PHASE_INC_C, inc_c);
      csr_write(REG_ATTACK_SAMPLES, att);
      csr_write(REG_RELEASE_SAMPLES, rel);
      csr_write(REG_TOTAL_SAMPLES, total);
      csr_write(REG_ATTACK_SLOPE, att_slope);
      csr_write(REG_RELEASE_SLOPE, rel_slope);
   endtask

   task automatic send_index(input logic [INDEX_WIDTH-1:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.sample_index <= idx;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // lower valid, wait for every sample in flight, then let the pipe settle
   task automatic drain_pipe();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pcm_expect.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      send_index(24'd0);
      send_index(24'd1);
      send_index(24'd22049);
      send_index(24'd22050);
      send_index(24'd66150);
      send_index(24'd88199);
      send_index(24'd88200);
      send_index(24'hFFFFFF);
      drain_pipe();
   endtask

   task automatic test_edge_settings();
      // release longer than the note, ramps saturating at unity
      write_note(32'h0, 32'hFFFFFFFF, 32'h80000000, 32'd0, 32'hFFFFFF, 32'd16,
                 32'h1000000, 32'h1000000);
      send_index(24'd0);
      send_index(24'd7);
      send_index(24'd15);
      send_index(24'd16);
      send_index(24'd17);
      drain_pipe();
      // longest note with the shallowest ramps
      write_note(32'h55555555, 32'hAAAAAAAA, 32'h01234567, 32'hFFFFFF, 32'hFFFFFF,
                 32'hFFFFFF, 32'd1, 32'd1);
      send_index(24'd0);
      send_index(24'h800000);
      send_index(24'hFFFFFE);
      send_index(24'hFFFFFF);
      drain_pipe();
      // zero-length note: nothing sounds and no last flag
      csr_write(REG_TOTAL_SAMPLES, 32'd0);
      send_index(24'd0);
      send_index(24'hFFFFFF);
      drain_pipe();
      csr_write(REG_TOTAL_SAMPLES, 32'd1);
      csr_write(REG_ATTACK_SLOPE, 32'd0);
      send_index(24'd0);
      drain_pipe();
   endtask

   task automatic pick_note(input int variant);
      longint total;
      longint att;
      longint rel;
      longint att_slope;
      longint rel_slope;
      logic [31:0] incs [3];
      for (int t = 0; t < 3; t++) begin
         incs[t] = $urandom();
         if (variant == 2 && $urandom_range(2) == 0) begin
            incs[t] = $urandom_range(1) ? 32'hFFFFFFFF : 32'h0;
         end
      end
      if (variant == 0) begin
         total     = $urandom_range(4000, 64);
         att       = $urandom_range(32'(total), 0);
         rel       = $urandom_range(32'(total), 0);
         att_slope = (att > 0) ? UNITY_Q24 / att + $urandom_range(2) : $urandom_range(1 << 24);
         rel_slope = (rel > 0) ? UNITY_Q24 / rel + $urandom_range(2) : $urandom_range(1 << 24);
      end else if (variant == 1) begin
         total     = $urandom_range(300, 1);
         att       = $urandom_range(600);
         rel       = $urandom_range(600);
         att_slope = $urandom_range(1 << 24);
         rel_slope = $urandom_range(1 << 24);
      end else begin
         total     = $urandom_range(1) ? MAX_INDEX
                                       : longint'($urandom_range(32'(MAX_INDEX), 1));
         att       = $urandom_range(1) ? MAX_INDEX : longint'($urandom_range(32'(MAX_INDEX)));
         rel       = $urandom_range(1) ? MAX_INDEX : longint'($urandom_range(32'(MAX_INDEX)));
         att_slope = $urandom_range(1) ? UNITY_Q24 : longint'($urandom_range(3));
         rel_slope = $urandom_range(1) ? UNITY_Q24 : longint'($urandom_range(1 << 24));
      end
      write_note(incs[0], incs[1], incs[2], 32'(att), 32'(rel), 32'(total),
                 32'(att_slope), 32'(rel_slope));
   endtask

   task automatic test_random_notes();
      int idle_modes [4][2] = '{'{0, 0}, '{61, 0}, '{0, 61}, '{35, 35}};
      for (int m = 0; m < 4; m++) begin
         send_idle_pct  = idle_modes[m][0];
         recv_stall_pct = idle_modes[m][1];
         for (int variant = 0; variant < 3; variant++) begin
            pick_note(variant);
            repeat (100) send_index(random_index());
            drain_pipe();
         end
      end
   endtask

   // receiver holds off long enough that the pipeline fills and stalls the input
   task automatic test_output_hold_off();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      pick_note(0);
      hold_requests <= hold_requests + 1;
      repeat (60) send_index(random_index());
      drain_pipe();
   endtask

   always @(posedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served   <= hold_requests;
         stall_hold    <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (stall_hold > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_hold    <= stall_hold - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         pcm_expect.push_back(synth_sample(req_bus.sample_index));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pcm_expect.size() == 0) begin
            $error("pcm item with no sample pending: pcm_sample %0d last_sample %0b",
                   rsp_bus.pcm_sample, rsp_bus.last_sample);
            mismatches++;
         end else begin
            if (rsp_bus.pcm_sample !== pcm_expect[0].pcm_sample) begin
               $error("pcm_sample: expected %0d, got %0d", pcm_expect[0].pcm_sample,
                      rsp_bus.pcm_sample);
               mismatches++;
            end
            if (rsp_bus.last_sample !== pcm_expect[0].last_sample) begin
               $error("last_sample: expected %0b, got %0b", pcm_expect[0].last_sample,
                      rsp_bus.last_sample);
               mismatches++;
            end
            void'(pcm_expect.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("enveloped_three_tone_synth_core verification failed");
         $finish;
      end
   end

   initial begin
      reset                <= 1'b1;
      psel                 <= 1'b0;
      penable              <= 1'b0;
      pwrite               <= 1'b0;
      paddr                <= '0;
      pwdata               <= '0;
      req_bus.valid        <= 1'b0;
      req_bus.sample_index <= '0;
      tabulate_sine();
      note_cfg.phase_inc_a     = PHASE_INC_A_RESET;
      note_cfg.phase_inc_b     = PHASE_INC_B_RESET;
      note_cfg.phase_inc_c     = PHASE_INC_C_RESET;
      note_cfg.attack_samples  = ATTACK_SAMPLES_RESET;
      note_cfg.release_samples = RELEASE_SAMPLES_RESET;
      note_cfg.total_samples   = TOTAL_SAMPLES_RESET;
      note_cfg.attack_slope    = ATTACK_SLOPE_RESET;
      note_cfg.release_slope   = RELEASE_SLOPE_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_edge_settings();
      test_random_notes();
      test_output_hold_off();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      drain_pipe();
      if (mismatches == 0 && pcm_expect.size() == 0) begin
         $display("enveloped_three_tone_synth_core verification clean");
      end else begin
         $display("enveloped_three_tone_synth_core verification failed");
      end
      $finish;
   end

endmodule

### files.f
hdl/etts_pkg.sv
hdl/etts_ifs.sv
hdl/etts_csr.sv
hdl/etts_sine_rom.sv
hdl/etts_envelope.sv
hdl/enveloped_three_tone_synth_core.sv
tb/sv/testbench.sv
